FILE: sv/aoc_pkg.sv
// shared types and constants for the alpha over compositor
package aoc_pkg;

  localparam int unsigned ChW    = 8;
  localparam int unsigned DivW   = 16;
  localparam int unsigned NumW   = 24;
  localparam int unsigned DshW   = DivW + ChW - 1;
  localparam int unsigned NLanes = 4;
  localparam int unsigned NCells = ChW;

  localparam logic [ChW-1:0] ChMax = 8'd255;

  // lane order inside the divider row
  localparam int unsigned LaneRed   = 0;
  localparam int unsigned LaneGreen = 1;
  localparam int unsigned LaneBlue  = 2;
  localparam int unsigned LaneAlpha = 3;

  typedef struct packed {
    logic [ChW-1:0] src_red;
    logic [ChW-1:0] src_green;
    logic [ChW-1:0] src_blue;
    logic [ChW-1:0] src_alpha;
    logic [ChW-1:0] dst_red;
    logic [ChW-1:0] dst_green;
    logic [ChW-1:0] dst_blue;
    logic [ChW-1:0] dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [ChW-1:0] out_red;
    logic [ChW-1:0] out_green;
    logic [ChW-1:0] out_blue;
    logic [ChW-1:0] out_alpha;
    logic           kept_destination;
  } pix_out_t;

  // one division lane: partial remainder, aligned divisor, quotient so far
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [DshW-1:0] dsh;
    logic [ChW-1:0]  quo;
  } lane_t;

  typedef struct packed {
    lane_t [NLanes-1:0] lane;
    logic               kept;
  } cell_t;

endpackage

FILE: sv/aoc_prep.sv
// two front stages: products, then numerators and divisors per lane
module aoc_prep import aoc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  pix_in_t data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output cell_t   data_o
);

  typedef struct packed {
    pix_in_t          pix;
    logic [2:0][15:0] ps;
    logic [15:0]      wa;
  } prod_t;

  logic  a_valid_q, b_valid_q;
  prod_t a_q, a_d;
  cell_t b_q, b_d;
  logic  a_ready, b_ready;

  assign b_ready = !b_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign ready_o = a_ready;
  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  // stage a: source color times source alpha, dst alpha times (255 - as)
  always_comb begin
    a_d.pix   = data_i;
    a_d.ps[0] = 16'(data_i.src_red)   * 16'(data_i.src_alpha);
    a_d.ps[1] = 16'(data_i.src_green) * 16'(data_i.src_alpha);
    a_d.ps[2] = 16'(data_i.src_blue)  * 16'(data_i.src_alpha);
    a_d.wa    = 16'(data_i.dst_alpha) * 16'(ChMax - data_i.src_alpha);
  end

  // stage b: build numerator and divisor for each lane
  always_comb begin
    logic [ChW-1:0] src_c [3];
    logic [ChW-1:0] dst_c [3];
    logic [DivW-1:0] den;
    logic [NumW-1:0] num;
    src_c[0] = a_q.pix.src_red;
    src_c[1] = a_q.pix.src_green;
    src_c[2] = a_q.pix.src_blue;
    dst_c[0] = a_q.pix.dst_red;
    dst_c[1] = a_q.pix.dst_green;
    dst_c[2] = a_q.pix.dst_blue;
    den = DivW'({a_q.pix.src_alpha, 8'd0}) - DivW'(a_q.pix.src_alpha) + a_q.wa;
    b_d = '0;
    b_d.kept = 1'b0;
    for (int i = 0; i < 3; i++) begin
      num = {a_q.ps[i], 8'd0} - NumW'(a_q.ps[i]) + NumW'(dst_c[i]) * NumW'(a_q.wa);
      priority if (a_q.pix.src_alpha == '0) begin
        b_d.lane[i].rem = NumW'(dst_c[i]);
        b_d.lane[i].dsh = DshW'({DivW'(1), 7'd0});
      end else if (a_q.pix.src_alpha == ChMax) begin
        b_d.lane[i].rem = NumW'(src_c[i]);
        b_d.lane[i].dsh = DshW'({DivW'(1), 7'd0});
      end else begin
        b_d.lane[i].rem = num;
        b_d.lane[i].dsh = DshW'({den, 7'd0});
      end
    end
    priority if (a_q.pix.src_alpha == '0) begin
      b_d.lane[LaneAlpha].rem = NumW'(a_q.pix.dst_alpha);
      b_d.lane[LaneAlpha].dsh = DshW'({DivW'(1), 7'd0});
      b_d.kept = 1'b1;
    end else if (a_q.pix.src_alpha == ChMax) begin
      b_d.lane[LaneAlpha].rem = NumW'(ChMax);
      b_d.lane[LaneAlpha].dsh = DshW'({DivW'(1), 7'd0});
    end else begin
      b_d.lane[LaneAlpha].rem = NumW'(den);
      b_d.lane[LaneAlpha].dsh = DshW'({DivW'(ChMax), 7'd0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && valid_i) a_q <= a_d;
    if (b_ready && a_valid_q) b_q <= b_d;
  end

endmodule

FILE: sv/aoc_div_cell.sv
// one restoring division step for all lanes, one quotient bit per cell
module aoc_div_cell import aoc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  cell_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output cell_t data_o
);

  logic  valid_q;
  cell_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    logic take;
    data_d = data_i;
    for (int i = 0; i < NLanes; i++) begin
      take = data_i.lane[i].rem >= NumW'(data_i.lane[i].dsh);
      if (take) data_d.lane[i].rem = data_i.lane[i].rem - NumW'(data_i.lane[i].dsh);
      data_d.lane[i].dsh = data_i.lane[i].dsh >> 1;
      data_d.lane[i].quo = {data_i.lane[i].quo[ChW-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) data_q <= data_d;
  end

endmodule

FILE: sv/alpha_over_compositor.sv
// top level: porter-duff over blend of one rgba8 pixel pair per beat
//
// input channel in_valid_i/in_ready_o carries one source and one
// destination pixel per beat (pix_in_t); output channel out_valid_o/
// out_ready_i returns the blended pixel plus kept_destination (pix_out_t)
// two front stages form products, numerators and divisors, then a row of 8
// divider cells each resolves one quotient bit for red, green, blue and
// alpha together
// throughput is one beat per cycle while out_ready_i is high; every stage
// holds its own valid bit so bubbles collapse and a new beat is taken while
// a finished result waits in the last cell, which is the output register
// transparent and opaque source pixels ride the same row with divisor 1
// reset clears all valid bits; payload registers are not reset
// when the receiver stalls the row fills up and in_ready_o drops only
// once every stage holds a beat
module alpha_over_compositor import aoc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pix_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pix_out_t out_data_o
);

  // row links: index 0 is the front end output, index NCells the last cell
  logic  row_valid [NCells+1];
  logic  row_ready [NCells+1];
  cell_t row_data  [NCells+1];

  aoc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (row_valid[0]),
    .ready_i (row_ready[0]),
    .data_o  (row_data[0])
  );

  for (genvar g = 0; g < NCells; g++) begin : g_cell
    aoc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (row_valid[g]),
      .ready_o (row_ready[g]),
      .data_i  (row_data[g]),
      .valid_o (row_valid[g+1]),
      .ready_i (row_ready[g+1]),
      .data_o  (row_data[g+1])
    );
  end

  // the last cell output is the result register
  assign row_ready[NCells] = out_ready_i;
  assign out_valid_o       = row_valid[NCells];

  always_comb begin
    out_data_o.out_red          = row_data[NCells].lane[LaneRed].quo;
    out_data_o.out_green        = row_data[NCells].lane[LaneGreen].quo;
    out_data_o.out_blue         = row_data[NCells].lane[LaneBlue].quo;
    out_data_o.out_alpha        = row_data[NCells].lane[LaneAlpha].quo;
    out_data_o.kept_destination = row_data[NCells].kept;
  end

`ifndef ASSERT_OFF
  // input back-pressure only when the whole row is full and blocked
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && row_valid[0]))
    else $error("input stalled while row has room");

  // pass-through beats enter the divider with unit divisors
  a_kept_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_valid[0] && row_data[0].kept) |->
      (row_data[0].lane[LaneAlpha].dsh == DshW'({DivW'(1), 7'd0})
       && row_data[0].lane[LaneRed].dsh == DshW'({DivW'(1), 7'd0})))
    else $error("pass-through beat has non-unit divisor");

  // a result can only appear after the previous cell held a beat
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(row_valid[NCells-1]))
    else $error("result appeared from an empty cell");
`endif

endmodule
